>>> rtl/compass_heading_smoother_macros.svh
// Assertion macros shared by the compass heading smoother RTL.
`ifndef COMPASS_HEADING_SMOOTHER_MACROS_SVH
`define COMPASS_HEADING_SMOOTHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define CHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/chs_pkg.sv
// Shared types and constants of the compass heading smoother.
package chs_pkg;
  localparam int CordicSteps = 24;
  localparam logic signed [35:0] Q24PiHalf = 36'sd26353589;
  localparam logic signed [35:0] Q24TwoPi  = 36'sd105414357;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_X_LOW  = 3'd0;
  localparam logic [2:0] REG_X_HIGH = 3'd1;
  localparam logic [2:0] REG_Y_LOW  = 3'd2;
  localparam logic [2:0] REG_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;

  // One queued sample: raw readings plus the calibration it was taken with.
  typedef struct packed {
    logic signed [19:0] mag_x;
    logic signed [19:0] mag_y;
    logic signed [16:0] x_low;
    logic signed [16:0] x_high;
    logic signed [16:0] y_low;
    logic signed [16:0] y_high;
    logic signed [10:0] offset;
  } sample_t;

  function automatic logic signed [35:0] atan_q24(input logic [4:0] i);
    logic signed [35:0] r;
    begin
      unique case (i)
        5'd0: r = 36'sd13176795;
        5'd1: r = 36'sd7778716;
        5'd2: r = 36'sd4110060;
        5'd3: r = 36'sd2086331;
        5'd4: r = 36'sd1047214;
        5'd5: r = 36'sd524117;
        5'd6: r = 36'sd262123;
        5'd7: r = 36'sd131069;
        default: r = (i < 5'd24) ? (36'sd1 <<< (5'd24 - i)) : 36'sd0;
      endcase
      return r;
    end
  endfunction
endpackage

>>> rtl/chs_queue.sv
// Two-entry queue between the sample front end and the heading engine.
module chs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  chs_pkg::sample_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output chs_pkg::sample_t rd_data
);
  chs_pkg::sample_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

>>> rtl/chs_engine.sv
// Heading engine: axis remap by serial division, CORDIC, fold and boxcar average.
module chs_engine #(
  parameter int WINDOW_LEN = 200
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chs_pkg::sample_t in_data,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [7:0]       res_avg,
  output logic [7:0]       res_heading,
  output logic             res_upper,
  output logic             res_fault
);
  localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SW = $clog2(180 * WINDOW_LEN + 1);
  localparam logic [PW-1:0] LastIdx = PW'(WINDOW_LEN - 1);

  // Average by reciprocal multiplication; the shift keeps the rounding error
  // below one for every reachable window sum.
  localparam int AvgShift = SW + PW;
  localparam int AvgMulW  = AvgShift + 1;
  localparam int AvgProdW = SW + AvgMulW;
  localparam logic [AvgMulW-1:0] AvgMul =
    AvgMulW'(((64'd1 << AvgShift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  // Reciprocals of 314 and 313 scaled by 2^25 for the fold.
  localparam logic [32:0] RecipLow  = 33'd106862;
  localparam logic [32:0] RecipHigh = 33'd107203;

  localparam logic [3:0] S_IDLE = 4'd0, S_DIVX = 4'd1, S_DIVY = 4'd2, S_PRE = 4'd3,
                         S_CORD = 4'd4, S_ANG = 4'd5, S_WRAP = 4'd6, S_FOLD = 4'd7,
                         S_RDW = 4'd8, S_SUM = 4'd9, S_AVG = 4'd10, S_OUT = 4'd11,
                         S_CLR = 4'd12;

  logic [3:0] st_r;
  chs_pkg::sample_t smp_r;
  // Serial divider: unsigned magnitude, 31-bit dividend, 18-bit divisor.
  logic [30:0] dq_r;
  logic [18:0] rem_r;
  logic [17:0] dvs_r;
  logic        dneg_r;
  logic [4:0]  cnt_r;
  logic signed [31:0] mx_r, my_r;
  logic        fault_r;
  logic signed [59:0] cx_r, cy_r;
  logic signed [35:0] cz_r;
  logic        zero_r;
  logic signed [11:0] w_r;
  logic [7:0]  h_r;
  logic        upper_r;
  logic [7:0]  win_mem [WINDOW_LEN];
  logic [7:0]  old_r;
  logic [PW-1:0] ptr_r;
  logic [SW-1:0] sum_r;
  logic [7:0]  avg_r;

  // Division setup helper values.
  logic signed [17:0] dx, dy;
  logic signed [21:0] nx, ny;
  logic signed [32:0] px, py;
  assign dx = 18'(smp_r.x_high) - 18'(smp_r.x_low);
  assign dy = 18'(smp_r.y_high) - 18'(smp_r.y_low);
  assign nx = 22'(smp_r.mag_x) - 22'(smp_r.x_low);
  assign ny = 22'(smp_r.mag_y) - 22'(smp_r.y_low);
  assign px = 33'(nx) * 33'sd2000;
  assign py = 33'(ny) * 33'sd2000;

  logic [19:0] trial;
  assign trial = {rem_r[17:0], dq_r[30]} - {1'b0, 1'b0, dvs_r};
  logic [18:0] sh;
  assign sh = {rem_r[17:0], dq_r[30]};
  logic signed [31:0] qsig;
  assign qsig = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  logic signed [59:0] xs, ys;
  assign xs = cx_r >>> cnt_r;
  assign ys = cy_r >>> cnt_r;

  logic signed [42:0] zp;
  assign zp = 43'(cz_r) * 43'sd100;

  logic [15:0] fnum;
  assign fnum = (w_r <= 12'sd314) ? 16'(w_r) * 16'd180 : 16'(w_r - 12'sd315) * 16'd180;
  logic [32:0] fprod;
  assign fprod = (w_r <= 12'sd314) ? 33'(fnum) * RecipLow : 33'(fnum) * RecipHigh;

  logic [AvgProdW-1:0] avg_prod;
  assign avg_prod = AvgProdW'(sum_r) * AvgProdW'(AvgMul);

  assign in_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res_avg = avg_r;
  assign res_heading = h_r;
  assign res_upper = upper_r;
  assign res_fault = fault_r;

  always_ff @(posedge clk) begin
    if (st_r == S_CLR) win_mem[ptr_r] <= '0;
    else if (st_r == S_SUM) win_mem[ptr_r] <= h_r;
    if (st_r == S_RDW) old_r <= win_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      ptr_r <= '0;
      sum_r <= '0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          if (ptr_r == LastIdx) begin
            ptr_r <= '0;
            st_r  <= S_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            smp_r <= in_data;
            st_r  <= S_DIVX;
            cnt_r <= 5'd0;
            fault_r <= 1'b0;
          end
        end
        S_DIVX, S_DIVY: begin
          if (cnt_r == 5'd0) begin
            logic signed [32:0] p;
            logic signed [17:0] d;
            p = (st_r == S_DIVX) ? px : py;
            d = (st_r == S_DIVX) ? dx : dy;
            dq_r   <= 31'(p[32] ? -p : p) << 0;
            dvs_r  <= 18'(d[17] ? -d : d);
            dneg_r <= p[32] ^ d[17];
            rem_r  <= '0;
            if (d == 18'sd0) begin
              fault_r <= 1'b1;
              if (st_r == S_DIVX) mx_r <= '0; else my_r <= '0;
              st_r  <= (st_r == S_DIVX) ? S_DIVY : S_PRE;
            end else begin
              cnt_r <= 5'd1;
            end
          end else begin
            if (!trial[19]) begin
              rem_r <= trial[18:0];
              dq_r  <= {dq_r[29:0], 1'b1};
            end else begin
              rem_r <= sh;
              dq_r  <= {dq_r[29:0], 1'b0};
            end
            if (cnt_r == 5'd31) begin
              cnt_r <= 5'd0;
              st_r  <= (st_r == S_DIVX) ? S_DIVY : S_PRE;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
          // Quotient stored when the shift completes (see S_PRE/S_DIVY entry below).
          if (cnt_r == 5'd0 && st_r == S_DIVY && dx != 18'sd0) mx_r <= qsig - 32'sd1000;
        end
        S_PRE: begin
          // Abscissa is the mapped Y, ordinate the mapped X.
          logic signed [31:0] my_v;
          logic signed [59:0] ax, ay;
          my_v = (dy != 18'sd0) ? qsig - 32'sd1000 : my_r;
          my_r <= my_v;
          zero_r <= (mx_r == 32'sd0) && (my_v == 32'sd0);
          ax = 60'(my_v) <<< 24;
          ay = 60'(mx_r) <<< 24;
          if (ax < 0) begin
            if (ay >= 0) begin
              cx_r <= ay; cy_r <= -ax; cz_r <= chs_pkg::Q24PiHalf;
            end else begin
              cx_r <= -ay; cy_r <= ax; cz_r <= -chs_pkg::Q24PiHalf;
            end
          end else begin
            cx_r <= ax; cy_r <= ay; cz_r <= '0;
          end
          cnt_r <= 5'd0;
          st_r  <= S_CORD;
        end
        S_CORD: begin
          if (!cy_r[59]) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs;
            cz_r <= cz_r + chs_pkg::atan_q24(cnt_r);
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs;
            cz_r <= cz_r - chs_pkg::atan_q24(cnt_r);
          end
          if (cnt_r == 5'(chs_pkg::CordicSteps - 1)) st_r <= S_ANG;
          cnt_r <= cnt_r + 5'd1;
        end
        S_ANG: begin
          logic signed [35:0] z;
          z = cz_r[35] ? cz_r + chs_pkg::Q24TwoPi : cz_r;
          if (z < 0) z = '0;
          cz_r <= z;
          st_r <= S_WRAP;
        end
        S_WRAP: begin
          logic signed [18:0] t;
          logic signed [11:0] a, w;
          t = 19'(zp >>> 24);
          a = zero_r ? 12'sd0 : ((t > 19'sd628) ? 12'sd628 : 12'(t));
          w = a + 12'(smp_r.offset);
          if (w > 12'sd628) w = w - 12'sd628;
          else if (w < 12'sd0) w = w + 12'sd628;
          if (w < 12'sd0) w = 12'sd0;
          if (w > 12'sd628) w = 12'sd628;
          w_r  <= w;
          st_r <= S_FOLD;
        end
        S_FOLD: begin
          if (w_r <= 12'sd314) begin
            h_r <= fprod[32:25];
            upper_r <= 1'b0;
          end else begin
            h_r <= 8'd180 - fprod[32:25];
            upper_r <= 1'b1;
          end
          st_r <= S_RDW;
        end
        S_RDW: st_r <= S_SUM;
        S_SUM: begin
          sum_r <= sum_r - SW'(old_r) + SW'(h_r);
          ptr_r <= (ptr_r == LastIdx) ? '0 : ptr_r + 1'b1;
          st_r  <= S_AVG;
        end
        S_AVG: begin
          avg_r <= avg_prod[AvgShift +: 8];
          st_r  <= S_OUT;
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/compass_heading_smoother.sv
// Top level of the compass heading smoother: config registers, front end, queue and engine.
//
//  channel  | dir | beat contents
//  in_      | in  | tdata: mag_x[19:0], mag_y[39:20]
//  out_     | out | tdata: avg_heading[7:0], heading[15:8], upper_half[16], range_fault[17]
//  cfg_     | in  | APB registers x_low, x_high, y_low, y_high, heading_offset
//
// The engine works on one beat at a time: each beat passes through two serial
// divisions and the 24-step CORDIC loop; an axis with a zero-width range skips
// its division. After reset the engine clears the window memory and accepts no
// work until it is done; the front end still queues up to two beats. Either side
// may stall freely; results wait in the engine's output register until taken.
`include "compass_heading_smoother_macros.svh"
module compass_heading_smoother #(
  parameter int WINDOW_LEN = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mag_x, mag_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // avg_heading, heading, upper_half, range_fault
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic signed [16:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic signed [10:0] offset_r;
  logic [2:0] idx;
  chs_pkg::sample_t smp, q_data;
  logic q_valid, q_ready;
  logic [7:0] avg, hd;
  logic up, flt;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r <= -17'sd1000; x_high_r <= 17'sd1000;
      y_low_r <= -17'sd1000; y_high_r <= 17'sd1000;
      offset_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        chs_pkg::REG_X_LOW:  x_low_r  <= cfg_pwdata[16:0];
        chs_pkg::REG_X_HIGH: x_high_r <= cfg_pwdata[16:0];
        chs_pkg::REG_Y_LOW:  y_low_r  <= cfg_pwdata[16:0];
        chs_pkg::REG_Y_HIGH: y_high_r <= cfg_pwdata[16:0];
        chs_pkg::REG_OFFSET: offset_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      chs_pkg::REG_X_LOW:  cfg_prdata = 32'(x_low_r);
      chs_pkg::REG_X_HIGH: cfg_prdata = 32'(x_high_r);
      chs_pkg::REG_Y_LOW:  cfg_prdata = 32'(y_low_r);
      chs_pkg::REG_Y_HIGH: cfg_prdata = 32'(y_high_r);
      chs_pkg::REG_OFFSET: cfg_prdata = 32'(offset_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Front end: each beat is tagged with the calibration in force.
  always_comb begin
    smp.mag_x  = in_tdata[19:0];
    smp.mag_y  = in_tdata[39:20];
    smp.x_low  = x_low_r;
    smp.x_high = x_high_r;
    smp.y_low  = y_low_r;
    smp.y_high = y_high_r;
    smp.offset = offset_r;
  end

  chs_queue u_queue (
    .clk, .rst_n, .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(smp),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  chs_engine #(.WINDOW_LEN(WINDOW_LEN)) u_engine (
    .clk, .rst_n, .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_avg(avg),
    .res_heading(hd), .res_upper(up), .res_fault(flt)
  );

  assign out_tdata = {6'd0, flt, up, hd, avg};

  `CHS_ASSERT_IMP(a_heading_range, clk, rst_n, out_tvalid, hd <= 8'd180, "heading out of range")
  `CHS_ASSERT_IMP(a_avg_range, clk, rst_n, out_tvalid, avg <= 8'd180, "average out of range")
  `CHS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
endmodule
